### src/biquad_filter_section_defines.svh
// assertion macros used by the biquad section sequencer
`ifndef BIQUAD_FILTER_SECTION_DEFINES_SVH
`define BIQUAD_FILTER_SECTION_DEFINES_SVH

// clocked check with asynchronous reset held off
`define BQS_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same with a fixed message
`define BQS_ASSERT(lbl, clk, rst_n, prop) \
	`BQS_ASSERT_MSG(lbl, clk, rst_n, prop, "bqs check failed")

`endif

### src/bqs_pkg.sv
// types, register indexes and microcode table of the biquad section
package bqs_pkg;

	localparam int CFG_IDX_BITS = 3;
	localparam int STEP_BITS    = 3;
	localparam int GAIN_NUM     = 5;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_SOURCE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FEED_GAIN_0 = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FEED_GAIN_1 = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FEED_GAIN_2 = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BACK_GAIN_1 = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_BACK_GAIN_2 = 3'd5;

	// places in the gain array
	localparam int GI_A0 = 0;
	localparam int GI_A1 = 1;
	localparam int GI_A2 = 2;
	localparam int GI_B1 = 3;
	localparam int GI_B2 = 4;

	// program steps with a meaning outside the table
	localparam logic [STEP_BITS-1:0] STEP_IDLE = 3'd0;
	localparam logic [STEP_BITS-1:0] STEP_LOAD = 3'd1;
	localparam logic [STEP_BITS-1:0] STEP_OUT  = 3'd6;

	typedef enum logic [2:0] {
		MS_B1_D1,
		MS_B2_D2,
		MS_A1_D1,
		MS_A2_D2,
		MS_A0_W
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD_X,
		ACC_ADD,
		ACC_LOAD_HALF
	} acc_op_t;

	typedef enum logic [1:0] {
		FL_NEXT,
		FL_WAIT_IN,
		FL_WAIT_OUT
	} flow_t;

	typedef struct packed {
		logic     capture;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     w_en;
		logic     y_en;
		flow_t    flow;
	} ucode_t;

	// control program, one word per step
	function automatic ucode_t ucode_rom(logic [STEP_BITS-1:0] step);
		ucode_t uc;
		uc.capture = 1'b0;
		uc.mul_sel = MS_A0_W;
		uc.acc_op  = ACC_HOLD;
		uc.w_en    = 1'b0;
		uc.y_en    = 1'b0;
		uc.flow    = FL_NEXT;
		unique case (step)
			3'd0: begin
				uc.capture = 1'b1;
				uc.flow    = FL_WAIT_IN;
			end
			3'd1: begin
				uc.acc_op  = ACC_LOAD_X;
				uc.mul_sel = MS_B1_D1;
			end
			3'd2: begin
				uc.acc_op  = ACC_ADD;
				uc.mul_sel = MS_B2_D2;
			end
			3'd3: begin
				uc.w_en    = 1'b1;
				uc.acc_op  = ACC_LOAD_HALF;
				uc.mul_sel = MS_A1_D1;
			end
			3'd4: begin
				uc.acc_op  = ACC_ADD;
				uc.mul_sel = MS_A2_D2;
			end
			3'd5: begin
				uc.acc_op  = ACC_ADD;
				uc.mul_sel = MS_A0_W;
			end
			3'd6: begin
				// product register keeps a0*w while the output stalls
				uc.y_en    = 1'b1;
				uc.mul_sel = MS_A0_W;
				uc.flow    = FL_WAIT_OUT;
			end
			default: begin
				uc.flow = FL_NEXT;
			end
		endcase
		return uc;
	endfunction

endpackage

### src/bqs_in_if.sv
// input channel: sample and per-sample coefficients
interface bqs_in_if #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic signed [COEF_BITS-1:0]   in_feed_0;
	logic signed [COEF_BITS-1:0]   in_feed_1;
	logic signed [COEF_BITS-1:0]   in_feed_2;
	logic signed [COEF_BITS-1:0]   in_back_1;
	logic signed [COEF_BITS-1:0]   in_back_2;

	modport source (
		output valid, sample_in, in_feed_0, in_feed_1, in_feed_2, in_back_1, in_back_2,
		input  ready
	);
	modport sink (
		input  valid, sample_in, in_feed_0, in_feed_1, in_feed_2, in_back_1, in_back_2,
		output ready
	);
endinterface

### src/bqs_out_if.sv
// output channel: filtered sample
interface bqs_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (
		output valid, sample_out,
		input  ready
	);
	modport sink (
		input  valid, sample_out,
		output ready
	);
endinterface

### src/bqs_cfg_regs.sv
// configuration registers: coefficient source and the five gains
module bqs_cfg_regs #(
	parameter int COEF_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bqs_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
	input  logic [COEF_BITS-1:0]                 cfg_data,
	output logic                                 coef_source,
	output logic signed [COEF_BITS-1:0]          gain [bqs_pkg::GAIN_NUM]
);

	logic                        coef_source_q;
	logic signed [COEF_BITS-1:0] gain_q [bqs_pkg::GAIN_NUM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_source_q <= 1'b0;
			for (int i = 0; i < bqs_pkg::GAIN_NUM; i++) begin
				gain_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bqs_pkg::REG_COEF_SOURCE: coef_source_q <= cfg_data[0];
				bqs_pkg::REG_FEED_GAIN_0: gain_q[bqs_pkg::GI_A0] <= cfg_data;
				bqs_pkg::REG_FEED_GAIN_1: gain_q[bqs_pkg::GI_A1] <= cfg_data;
				bqs_pkg::REG_FEED_GAIN_2: gain_q[bqs_pkg::GI_A2] <= cfg_data;
				bqs_pkg::REG_BACK_GAIN_1: gain_q[bqs_pkg::GI_B1] <= cfg_data;
				bqs_pkg::REG_BACK_GAIN_2: gain_q[bqs_pkg::GI_B2] <= cfg_data;
				default: begin
					// unknown index: write dropped
				end
			endcase
		end
	end

	assign coef_source = coef_source_q;
	assign gain        = gain_q;

endmodule

### src/bqs_sequencer.sv
// step counter and microcode table driving the datapath
`include "biquad_filter_section_defines.svh"

module bqs_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_busy,
	output logic            in_ready,
	output bqs_pkg::ucode_t ctl
);

	logic [bqs_pkg::STEP_BITS-1:0] step_q, step_d;
	bqs_pkg::ucode_t               uc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= bqs_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		uc          = bqs_pkg::ucode_rom(step_q);
		ctl         = uc;
		ctl.capture = uc.capture & in_valid;
		ctl.y_en    = uc.y_en & ~out_busy;
		in_ready    = uc.capture;
		unique case (uc.flow)
			bqs_pkg::FL_WAIT_IN:  step_d = in_valid ? step_q + 3'd1 : step_q;
			bqs_pkg::FL_WAIT_OUT: step_d = out_busy ? step_q : bqs_pkg::STEP_IDLE;
			bqs_pkg::FL_NEXT:     step_d = step_q + 3'd1;
			default:              step_d = bqs_pkg::STEP_IDLE;
		endcase
	end

	`BQS_ASSERT(a_capture_starts, clk, arst_n, ctl.capture |=> step_q == bqs_pkg::STEP_LOAD)
	`BQS_ASSERT(a_result_ends, clk, arst_n, ctl.y_en |=> step_q == bqs_pkg::STEP_IDLE)
	`BQS_ASSERT(a_stall_holds, clk, arst_n, (step_q == bqs_pkg::STEP_OUT && out_busy) |=> step_q == bqs_pkg::STEP_OUT)
	`BQS_ASSERT(a_ready_only_idle, clk, arst_n, in_ready |-> (step_q == bqs_pkg::STEP_IDLE && !ctl.w_en && !ctl.y_en))

endmodule

### src/bqs_datapath.sv
// shared multiplier, accumulator, rounding and saturation, history and output register
module bqs_datapath #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16,
	parameter int STATE_BITS  = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bqs_pkg::ucode_t               ctl,
	input  logic                          coef_source,
	input  logic signed [COEF_BITS-1:0]   cfg_gain [bqs_pkg::GAIN_NUM],
	input  logic signed [SAMPLE_BITS-1:0] x_in,
	input  logic signed [COEF_BITS-1:0]   in_gain [bqs_pkg::GAIN_NUM],
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] y_out,
	output logic                          out_busy
);

	localparam int FRAC   = COEF_BITS - 2;
	localparam int PROD_W = COEF_BITS + STATE_BITS;
	localparam int XSH_W  = SAMPLE_BITS + FRAC;
	localparam int ACC_W  = ((PROD_W > XSH_W) ? PROD_W : XSH_W) + 2;

	localparam logic signed [ACC_W-1:0] HALF =
		{{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] W_MAX =
		{{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] W_MIN = ~W_MAX;
	localparam logic signed [ACC_W-1:0] Y_MAX =
		{{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [COEF_BITS-1:0]   gain_q [bqs_pkg::GAIN_NUM];
	logic signed [STATE_BITS-1:0]  d1_q, d2_q, w_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic                          out_valid_q;

	logic signed [COEF_BITS-1:0]   mul_a;
	logic signed [STATE_BITS-1:0]  mul_b;
	logic signed [ACC_W-1:0]       x_ext, prod_ext, sum, sh;
	logic signed [STATE_BITS-1:0]  w_d;
	logic signed [SAMPLE_BITS-1:0] y_d;

	always_comb begin
		case (ctl.mul_sel)
			bqs_pkg::MS_B1_D1: begin mul_a = gain_q[bqs_pkg::GI_B1]; mul_b = d1_q; end
			bqs_pkg::MS_B2_D2: begin mul_a = gain_q[bqs_pkg::GI_B2]; mul_b = d2_q; end
			bqs_pkg::MS_A1_D1: begin mul_a = gain_q[bqs_pkg::GI_A1]; mul_b = d1_q; end
			bqs_pkg::MS_A2_D2: begin mul_a = gain_q[bqs_pkg::GI_A2]; mul_b = d2_q; end
			default:           begin mul_a = gain_q[bqs_pkg::GI_A0]; mul_b = w_q;  end
		endcase
	end

	// x in the accumulator format, half an lsb already in for rounding
	assign x_ext = {{(ACC_W-XSH_W){x_q[SAMPLE_BITS-1]}}, x_q, 1'b1, {(FRAC-1){1'b0}}};
	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign sum = acc_q + prod_ext;
	assign sh  = sum >>> FRAC;

	always_comb begin
		if (sh > W_MAX) begin
			w_d = W_MAX[STATE_BITS-1:0];
		end else if (sh < W_MIN) begin
			w_d = W_MIN[STATE_BITS-1:0];
		end else begin
			w_d = sh[STATE_BITS-1:0];
		end
		if (sh > Y_MAX) begin
			y_d = Y_MAX[SAMPLE_BITS-1:0];
		end else if (sh < Y_MIN) begin
			y_d = Y_MIN[SAMPLE_BITS-1:0];
		end else begin
			y_d = sh[SAMPLE_BITS-1:0];
		end
	end

	// operands and arithmetic registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			x_q <= x_in;
			for (int i = 0; i < bqs_pkg::GAIN_NUM; i++) begin
				gain_q[i] <= coef_source ? in_gain[i] : cfg_gain[i];
			end
		end
		prod_q <= mul_a * mul_b;
		case (ctl.acc_op)
			bqs_pkg::ACC_LOAD_X:    acc_q <= x_ext;
			bqs_pkg::ACC_ADD:       acc_q <= sum;
			bqs_pkg::ACC_LOAD_HALF: acc_q <= HALF;
			default:                acc_q <= acc_q;
		endcase
		if (ctl.w_en) begin
			w_q <= w_d;
		end
		if (ctl.y_en) begin
			y_q <= y_d;
		end
	end

	// filter history and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q        <= '0;
			d2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.y_en) begin
				d2_q <= d1_q;
				d1_q <= w_q;
			end
			if (ctl.y_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign y_out     = y_q;
	assign out_busy  = out_valid_q & ~out_ready;

endmodule

### src/biquad_filter_section.sv
// second-order direct form ii filter section, microcoded over one multiplier
//
//   channel  dir  transaction           payload
//   din      in   one input sample      sample_in, in_feed_0..2, in_back_1..2
//   dout     out  one filtered sample   sample_out
//   cfg      in   register write        cfg_idx, cfg_data
//
// a sample is captured at the first step, then six program steps run the
// five products through the single registered multiplier and accumulator
// the next sample is taken as soon as the program is back at its first step
// a finished sample waits in the output register; the program holds on its last
// step only while that register is still full and not being taken
// reset clears the history, the configuration registers and the step counter; no clearing pass
module biquad_filter_section #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16,
	parameter int STATE_BITS  = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bqs_in_if.sink                           din,
	bqs_out_if.source                        dout,
	input  logic                             cfg_we,
	input  logic [bqs_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [COEF_BITS-1:0]             cfg_data
);

	logic                        coef_source;
	logic signed [COEF_BITS-1:0] cfg_gain [bqs_pkg::GAIN_NUM];
	logic signed [COEF_BITS-1:0] in_gain  [bqs_pkg::GAIN_NUM];
	bqs_pkg::ucode_t             ctl;
	logic                        out_busy;

	assign in_gain[bqs_pkg::GI_A0] = din.in_feed_0;
	assign in_gain[bqs_pkg::GI_A1] = din.in_feed_1;
	assign in_gain[bqs_pkg::GI_A2] = din.in_feed_2;
	assign in_gain[bqs_pkg::GI_B1] = din.in_back_1;
	assign in_gain[bqs_pkg::GI_B2] = din.in_back_2;

	bqs_cfg_regs #(
		.COEF_BITS (COEF_BITS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.coef_source (coef_source),
		.gain        (cfg_gain)
	);

	bqs_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.out_busy (out_busy),
		.in_ready (din.ready),
		.ctl      (ctl)
	);

	bqs_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS),
		.STATE_BITS  (STATE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.coef_source (coef_source),
		.cfg_gain    (cfg_gain),
		.x_in        (din.sample_in),
		.in_gain     (in_gain),
		.out_ready   (dout.ready),
		.out_valid   (dout.valid),
		.y_out       (dout.sample_out),
		.out_busy    (out_busy)
	);

endmodule
